// File: design/b2d_pkg.sv
`default_nettype none
package b2d_pkg;

   // default width of the binary input
   localparam int VALUE_BITS_DEFAULT = 31;

   // width of one decimal digit
   localparam int DIGIT_BITS = 4;

   // decimal digits needed for an all-ones word of the given width
   // (1233 / 4096 approximates log10 of 2 closely enough up to 64 bits)
   function automatic int digits_for(input int bits);
      digits_for = ((bits * 1233) / 4096) + 1;
   endfunction

   // controller to datapath
   typedef struct packed {
      logic load;    // take a new item, clear the digit register
      logic shift;   // one double dabble step
      logic step;    // move to the next lower digit
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic idx_zero;   // digit pointer is at the least significant digit
   } status_type;

endpackage
`default_nettype wire

// File: design/b2d_datapath.sv
`default_nettype none
module b2d_datapath #(
   parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEFAULT
) (
   input  wire                               clock,
   input  wire  b2d_pkg::cmd_type            cmd,
   output b2d_pkg::status_type               status,
   input  wire  [VALUE_BITS-1:0]             req_value,
   output logic [b2d_pkg::DIGIT_BITS-1:0]    rsp_digit,
   output logic                              rsp_last
);

   localparam int DIGITS = b2d_pkg::digits_for(VALUE_BITS);
   localparam int DW     = b2d_pkg::DIGIT_BITS;
   localparam int BCD_W  = DIGITS * DW;
   localparam int IDX_W  = $clog2(DIGITS);

   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BCD_W-1:0]      adjusted;
   logic [BCD_W-1:0]      shifted;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      idx_up;
   logic                  grow;

   // add 3 to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*DW +: DW] >= DW'(5)) begin
            adjusted[i*DW +: DW] = bcd_ff[i*DW +: DW] + DW'(3);
         end else begin
            adjusted[i*DW +: DW] = bcd_ff[i*DW +: DW];
         end
      end
   end

   assign shifted = {adjusted[BCD_W-2:0], val_ff[VALUE_BITS-1]};
   assign idx_up  = idx_ff + IDX_W'(1);

   // the digit count grows by at most one per step, so only the digit
   // just above the current top needs a look
   always_comb begin
      grow = 1'b0;
      if (idx_ff != IDX_W'(DIGITS - 1)) begin
         grow = (shifted[{idx_up, 2'b00} +: DW] != '0);
      end
   end

   always_comb begin
      val_in = val_ff;
      bcd_in = bcd_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         val_in = req_value;
         bcd_in = '0;
         idx_in = '0;
      end else if (cmd.shift) begin
         val_in = {val_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = shifted;
         if (grow) begin
            idx_in = idx_up;
         end
      end else if (cmd.step) begin
         idx_in = idx_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      bcd_ff <= bcd_in;
      idx_ff <= idx_in;
   end

   assign rsp_digit       = bcd_ff[{idx_ff, 2'b00} +: DW];
   assign rsp_last        = (idx_ff == '0);
   assign status.idx_zero = (idx_ff == '0);

endmodule
`default_nettype wire

// File: design/b2d_controller.sv
`default_nettype none
module b2d_controller #(
   parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output b2d_pkg::cmd_type     cmd,
   input  wire  b2d_pkg::status_type status
);

   localparam int CNT_W = $clog2(VALUE_BITS);

   typedef enum logic [1:0] {
      IDLE,
      CONVERT,
      EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = CONVERT;
            end
         end
         CONVERT: begin
            cmd.shift = 1'b1;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.idx_zero) begin
                  state_in = IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// File: design/binary_to_decimal_digits.sv
// Binary to decimal digit converter. Each input item is an unsigned
// VALUE_BITS-bit integer; the block answers with its decimal digits, one
// result item per digit, most significant first, with no leading zeros and
// rsp_last set on the least significant digit. Zero gives a single digit 0
// with rsp_last set. Conversion is bit-serial double dabble: one input bit
// per cycle through a shift register and a row of add-3 digit cells. An
// item is accepted, its VALUE_BITS bits are shifted in, and then its digits
// are emitted, each one held until rsp_ready takes it.
// One item is worked on at a time; req_ready is high only between items.
`default_nettype none
module binary_to_decimal_digits #(
   parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEFAULT
) (
   input  wire                             clock,
   input  wire                             reset,
   // input channel
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [VALUE_BITS-1:0]           req_value,
   // result channel, one item per decimal digit
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [b2d_pkg::DIGIT_BITS-1:0]  rsp_digit,
   output logic                            rsp_last
);

   // command and status between sequencer and digit datapath
   b2d_pkg::cmd_type    cmd;
   b2d_pkg::status_type status;

   // sequencer: idle / convert (bit count) / emit (digit handshakes)
   b2d_controller #(
      .VALUE_BITS (VALUE_BITS)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // shift register, digit register and top digit pointer
   b2d_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .status    (status),
      .req_value (req_value),
      .rsp_digit (rsp_digit),
      .rsp_last  (rsp_last)
   );

endmodule
`default_nettype wire

// File: verif/binary_to_decimal_digits_tb.sv
// expected digit runs, one queue entry per decimal digit, oldest first
class digit_scoreboard #(int WIDTH = 31);
   typedef logic [b2d_pkg::DIGIT_BITS-1:0] digit_type;
   typedef struct packed {
      digit_type digit;
      logic      last;
   } digit_result_type;

   digit_result_type expected_digits[$];
   int unsigned      errors;
   int unsigned      values_noted;
   int unsigned      zero_values;
   int unsigned      digits_checked;
   int unsigned      longest_run;

   function new();
      errors         = 0;
      values_noted   = 0;
      zero_values    = 0;
      digits_checked = 0;
      longest_run    = 0;
   endfunction

   function int unsigned pending();
      return expected_digits.size();
   endfunction

   // split an accepted value into its digits, most significant queued first
   function void note_value(input logic [WIDTH-1:0] value);
      logic [63:0]      rest;
      digit_type        lsd_first[$];
      digit_result_type entry;
      int               k;
      rest = 64'(value);
      do begin
         lsd_first.push_back(digit_type'(rest % 64'd10));
         rest = rest / 64'd10;
      end while (rest != 64'd0);
      for (k = lsd_first.size() - 1; k >= 0; k--) begin
         entry.digit = lsd_first[k];
         entry.last  = (k == 0);
         expected_digits.push_back(entry);
      end
      values_noted++;
      if (value == '0) zero_values++;
      if (lsd_first.size() > longest_run) longest_run = lsd_first.size();
   endfunction

   task report(input string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   task check_digit(input digit_type digit, input logic last);
      digit_result_type want;
      digits_checked++;
      if (expected_digits.size() == 0) begin
         report($sformatf("digit %0d last %0b with no digit expected", digit, last));
      end else begin
         want = expected_digits.pop_front();
         if (digit !== want.digit)
            report($sformatf("digit %0d, expected %0d", digit, want.digit));
         if (last !== want.last)
            report($sformatf("last %0b on digit %0d, expected %0b", last, digit, want.last));
      end
   endtask
endclass

module binary_to_decimal_digits_tb;

   localparam int VALUE_BITS    = b2d_pkg::VALUE_BITS_DEFAULT;
   localparam int RANDOM_ITEMS  = 310;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT   = 600000;

   typedef enum int {
      READY_ALWAYS,
      READY_HALF,
      READY_EVERY_FOURTH,
      READY_MOSTLY
   } stall_mode_type;

   logic                           clock;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [VALUE_BITS-1:0]          req_value = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [b2d_pkg::DIGIT_BITS-1:0] rsp_digit;
   logic                           rsp_last;

   digit_scoreboard #(VALUE_BITS) sb;

   // receiver state
   int             hold_requests = 0;
   int             hold_served   = 0;
   int             hold_left     = 0;
   int             holds_done    = 0;
   stall_mode_type rx_mode       = READY_ALWAYS;
   int             rx_mode_left  = 0;
   int             rx_phase      = 0;

   int unsigned cycle_count   = 0;

   // edge values: zero, digit boundaries, bit patterns, full scale
   int unsigned directed_values[25] = '{
      0, 1, 9, 10, 11, 19, 99, 100, 101, 999, 1000, 65535, 99999, 100000,
      999999999, 1000000000, 1000000001, 1073741824, 1431655765, 715827882,
      2147483646, 2147483647, 2000000000, 1234567890, 987654321
   };

   binary_to_decimal_digits #(
      .VALUE_BITS(VALUE_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_digit (rsp_digit),
      .rsp_last  (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] pow10(input int k);
      logic [63:0] p;
      p = 64'd1;
      repeat (k) p = p * 64'd10;
      return p;
   endfunction

   // random value, spread over digit counts and the interesting corners
   function automatic logic [VALUE_BITS-1:0] pick_value();
      logic [63:0] top;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] v;
      int          d;
      top = (64'd1 << VALUE_BITS) - 64'd1;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            v = 64'($urandom) & top;
         end
         3, 4, 5: begin
            // uniform over the number of digits
            d  = $urandom_range(1, 10);
            lo = (d == 1) ? 64'd0 : pow10(d - 1);
            hi = pow10(d) - 64'd1;
            if (hi > top) hi = top;
            v  = lo + 64'($urandom) % (hi - lo + 64'd1);
         end
         6: begin
            v = 64'($urandom_range(0, 99));
         end
         7: begin
            // just around a power of ten
            v = pow10($urandom_range(1, 9)) + 64'($urandom_range(0, 2)) - 64'd1;
         end
         8: begin
            v = top - 64'($urandom_range(0, 15));
         end
         default: begin
            v = (top >> $urandom_range(0, VALUE_BITS - 1)) ^
                (64'd1 << $urandom_range(0, VALUE_BITS - 1));
         end
      endcase
      return VALUE_BITS'(v & top);
   endfunction

   // hold valid and the value until the block takes the item
   task automatic offer_value(input logic [VALUE_BITS-1:0] value);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid for a while, with noise on the value lines
   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         req_value <= VALUE_BITS'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // accepted items on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_value(req_value);
         if (rsp_valid && rsp_ready) sb.check_digit(rsp_digit, rsp_last);
      end
   end

   // receiver: long hold-offs on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD - 1;
         holds_done  = holds_done + 1;
         rsp_ready  <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = stall_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 200);
         end
         rx_mode_left = rx_mode_left - 1;
         rx_phase     = rx_phase + 1;
         case (rx_mode)
            READY_ALWAYS:       rsp_ready <= 1'b1;
            READY_HALF:         rsp_ready <= 1'($urandom_range(0, 1));
            READY_EVERY_FOURTH: rsp_ready <= ((rx_phase % 4) == 0);
            default:            rsp_ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d digits still expected",
                  cycle_count, sb.pending());
         $display("[binary_to_decimal_digits] ERROR");
         $finish;
      end
   end

   initial begin
      int  n;
      int  b;
      int  burst_len;
      bit  drained_mid;
      sb          = new();
      n           = 0;
      drained_mid = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners, short gaps
      foreach (directed_values[i]) begin
         offer_value(VALUE_BITS'(directed_values[i]));
         idle_sender($urandom_range(0, 3));
      end
      pause_until_drained();

      // random bursts
      while (n < RANDOM_ITEMS) begin
         burst_len = $urandom_range(1, 12);
         for (b = 0; b < burst_len && n < RANDOM_ITEMS; b++) begin
            offer_value(pick_value());
            n++;
            // receiver goes quiet while items keep coming
            if (n == 50 || n == 220) hold_requests <= hold_requests + 1;
         end
         if (!drained_mid && n >= 150) begin
            drained_mid = 1'b1;
            pause_until_drained();
         end else if ($urandom_range(0, 5) != 0) begin
            idle_sender($urandom_range(1, 20));
         end
      end

      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("converted %0d values (%0d zero), checked %0d digits, longest run %0d",
               sb.values_noted, sb.zero_values, sb.digits_checked, sb.longest_run);
      $display("%0d long receiver hold-offs, %0d mismatches, %0d cycles",
               holds_done, sb.errors, cycle_count);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[binary_to_decimal_digits] OK");
      end else begin
         $display("[binary_to_decimal_digits] ERROR");
      end
      $finish;
   end

endmodule

// File: binary_to_decimal_digits.f
design/b2d_pkg.sv
design/b2d_datapath.sv
design/b2d_controller.sv
design/binary_to_decimal_digits.sv
verif/binary_to_decimal_digits_tb.sv
